// ===== rtl/slipcrc_pkg.sv =====
// Shared types, SLIP codes and the byte-wide reflected CRC32 step for the
// SLIP deframer with CRC32 check. No dependencies.
package slipcrc_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 256;

   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   typedef enum logic [1:0] {
      STATUS_BUSY    = 2'd0,
      STATUS_DONE    = 2'd1,
      STATUS_FRAMING = 2'd2,
      STATUS_BADCRC  = 2'd3
   } status_type;

   typedef struct packed {
      status_type status;
      logic       data_valid;
      logic [7:0] data_out;
      logic [7:0] frame_length;
   } result_type;

   // One byte through the reflected CRC32, LSB first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/slipcrc_core.sv =====
// Unescape, trailer window, byte count and running CRC32 for one byte per
// request; computes the result item. Depends on slipcrc_pkg.
module slipcrc_core #(
   parameter int MAX_FRAME_BYTES = slipcrc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              rx_byte,
   output slipcrc_pkg::result_type result
);

   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES);
   localparam logic [CW-1:0] CNT_TRL = CW'(4);

   logic          escape_ff, escape_in;
   logic          clear_ff, clear_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    win_ff [4];
   logic [7:0]    win_in [4];
   logic [31:0]   crc_ff, crc_in;

   logic          esc_eff;
   logic [CW-1:0] cnt_eff;
   logic [7:0]    win_eff [4];
   logic [31:0]   crc_eff;
   logic          push;
   logic [7:0]    push_byte;
   logic [CW-1:0] len_w;

   always_comb begin
      // A pending clear restores reset state before this byte is handled.
      esc_eff = clear_ff ? 1'b0 : escape_ff;
      cnt_eff = clear_ff ? '0 : count_ff;
      crc_eff = clear_ff ? slipcrc_pkg::CRC_ONES : crc_ff;
      for (int i = 0; i < 4; i++) begin
         win_eff[i] = clear_ff ? 8'd0 : win_ff[i];
      end
      len_w = cnt_eff - CNT_TRL;

      escape_in = 1'b0;
      clear_in  = 1'b0;
      count_in  = cnt_eff;
      crc_in    = crc_eff;
      win_in    = win_eff;
      push      = 1'b0;
      push_byte = rx_byte;
      result    = '{status: slipcrc_pkg::STATUS_BUSY, data_valid: 1'b0,
                    data_out: 8'd0, frame_length: 8'd0};

      if (esc_eff) begin
         if (rx_byte == slipcrc_pkg::SLIP_ESC_END) begin
            push      = 1'b1;
            push_byte = slipcrc_pkg::SLIP_END;
         end else if (rx_byte == slipcrc_pkg::SLIP_ESC_ESC) begin
            push      = 1'b1;
            push_byte = slipcrc_pkg::SLIP_ESC;
         end else begin
            result.status = slipcrc_pkg::STATUS_FRAMING;
            clear_in      = 1'b1;
         end
      end else if (rx_byte == slipcrc_pkg::SLIP_END) begin
         clear_in = 1'b1;
         if (cnt_eff < CNT_TRL) begin
            result.status = (cnt_eff != '0) ? slipcrc_pkg::STATUS_FRAMING
                                            : slipcrc_pkg::STATUS_BUSY;
         end else if ((crc_eff ^ slipcrc_pkg::CRC_ONES) ==
                      {win_eff[3], win_eff[2], win_eff[1], win_eff[0]}) begin
            result.status       = slipcrc_pkg::STATUS_DONE;
            result.frame_length = 8'(len_w);
         end else begin
            result.status = slipcrc_pkg::STATUS_BADCRC;
         end
      end else if (rx_byte == slipcrc_pkg::SLIP_ESC) begin
         escape_in = 1'b1;
      end else begin
         push = 1'b1;
      end

      if (push) begin
         if (cnt_eff == CNT_MAX) begin
            // overflow: drop the byte
            result.status = slipcrc_pkg::STATUS_FRAMING;
            clear_in      = 1'b1;
         end else begin
            if (cnt_eff >= CNT_TRL) begin
               result.data_valid = 1'b1;
               result.data_out   = win_eff[0];
               crc_in            = slipcrc_pkg::crc_byte(crc_eff, win_eff[0]);
            end
            win_in[0] = win_eff[1];
            win_in[1] = win_eff[2];
            win_in[2] = win_eff[3];
            win_in[3] = push_byte;
            count_in  = cnt_eff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
         clear_ff  <= 1'b0;
         count_ff  <= '0;
         crc_ff    <= slipcrc_pkg::CRC_ONES;
         for (int i = 0; i < 4; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else if (accept) begin
         escape_ff <= escape_in;
         clear_ff  <= clear_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         win_ff    <= win_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("byte count above frame limit");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (result.status == slipcrc_pkg::STATUS_FRAMING ||
                 result.status == slipcrc_pkg::STATUS_BADCRC) |=> clear_ff)
      else $error("frame error did not schedule a clear");

   a_release_not_done: assert property (@(posedge clock) disable iff (reset)
      accept && result.data_valid |-> result.status == slipcrc_pkg::STATUS_BUSY)
      else $error("payload release together with frame end");

   a_escape_once: assert property (@(posedge clock) disable iff (reset)
      accept && esc_eff |=> !escape_ff)
      else $error("escape flag survived the escaped byte");
`endif

endmodule

// ===== rtl/slipcrc_out_reg.sv =====
// Result register for the SLIP deframer: holds one result until the
// downstream side takes it. Depends on slipcrc_pkg.
module slipcrc_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  slipcrc_pkg::result_type result,
   input  logic                    take,
   output logic                    valid,
   output slipcrc_pkg::result_type held
);

   logic                    valid_ff, valid_in;
   slipcrc_pkg::result_type held_ff;

   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= result;
      end
   end

   assign valid = valid_ff;
   assign held  = held_ff;

endmodule

// ===== rtl/slip_crc32_frame_decoder_top.sv =====
// Top level of the SLIP deframer with CRC32 trailer check.
// Depends on slipcrc_pkg, slipcrc_core and slipcrc_out_reg.
//
// Takes one raw serial byte per request and returns one result per request,
// registered in the result register. A new byte is taken every cycle
// while the result side keeps up; the unescape, window shift and byte-wide
// CRC32 update all sit between the state registers and the result register.
// Payload bytes are released four bytes late (the CRC trailer stays in the
// window); a frame's bytes must be dropped downstream unless its END reports
// status done. After END or an error the next byte starts a fresh frame.
module slip_crc32_frame_decoder_top #(
   parameter int MAX_FRAME_BYTES = slipcrc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_out, [15:8] frame_length
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] data_valid
);

   logic                    accept;
   slipcrc_pkg::result_type result;
   slipcrc_pkg::result_type held;

   // take a request whenever the result register is free or being emptied
   assign req_tready = ~rsp_tvalid | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   slipcrc_core #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .result  (result)
   );

   slipcrc_out_reg u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .result (result),
      .take   (rsp_tready),
      .valid  (rsp_tvalid),
      .held   (held)
   );

   assign rsp_tdata = {held.frame_length, held.data_out};
   assign rsp_tuser = {held.data_valid, held.status};

endmodule
